@@ rtl/tcm_pkg.sv @@
`default_nettype none

package tcm_pkg;

    // Trend divider: |dAlt| * 1000 fits 34 bits, the time span 32 bits.
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 32;
    localparam int QCNT_W = 6;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    localparam logic [NUM_W-1:0] TREND_POS_LIM = 34'd8388607;
    localparam logic [NUM_W-1:0] TREND_NEG_LIM = 34'd8388608;
    localparam logic [23:0] TREND_MAX = 24'h7FFFFF;
    localparam logic [23:0] TREND_MIN = 24'h800000;

    localparam logic [2:0] ST_NO_POS  = 3'd0;
    localparam logic [2:0] ST_NO_TERR = 3'd1;
    localparam logic [2:0] ST_CLEAR   = 3'd2;
    localparam logic [2:0] ST_CAUTION = 3'd3;
    localparam logic [2:0] ST_WARNING = 3'd4;

    localparam logic REG_WARNING = 1'b0;
    localparam logic REG_CAUTION = 1'b1;

endpackage

`default_nettype wire

@@ rtl/tcm_ram.sv @@
`default_nettype none

module tcm_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 30
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/tcm_div.sv @@
`default_nettype none

module tcm_div
    import tcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo
);

    localparam logic [QCNT_W-1:0] LAST_STEP = QCNT_W'(NUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              fits;

    // One restoring step per cycle; the dividend shifts out of r_q as
    // quotient bits shift in.
    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

@@ rtl/terrain_clearance_monitor.sv @@
// Terrain clearance monitor. A beat with tuser 0 appends an altitude/time
// sample to a ring of the last WINDOW_DEPTH samples; it leaves the sequencer
// idle and gives no result. A beat with tuser 1 analyzes the current
// position and gives one result beat: height above ground, home-relative
// altitude, the least clearance over the current altitude and the stored
// samples, the oldest-to-newest clearance trend in cm/s and a status: no
// position, no terrain, or clear/caution/warning set by the two APB
// thresholds. When position or terrain is invalid the sequencer goes
// straight to its finish state, from which the result register loads once
// the output is free. Otherwise the ring is read one sample per cycle
// through its single read port. Without a trend (fewer than two samples, or
// a newest timestamp that is not later than the oldest) the sequencer goes
// from the scan through a prep state to the finish state. With a trend, the
// value goes through a radix-2 divider of 34 steps. s_axis_tready is low
// while an analyze is in progress; a finished result waits in the output
// register and does not block further beats until the next result is ready.
`default_nettype none

module terrain_clearance_monitor
    import tcm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 30
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // APB configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // Input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, low bit up: sample_altitude_cm[23:0], sample_time_ms[55:24],
    // vehicle_altitude_cm[79:56], terrain_height_cm[103:80],
    // home_altitude_cm[127:104], position_valid[128], terrain_valid[129],
    // home_valid[130], zero fill[135:131]
    input  wire logic [135:0] s_axis_tdata,
    // tuser: cmd (0 append, 1 analyze)
    input  wire logic         s_axis_tuser,
    // Output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, low bit up: status[2:0], agl_cm[27:3], home_relative_cm[52:28],
    // home_valid_out[53], terrain_height_out_cm[77:54],
    // terrain_valid_out[78], trend_cm_per_s[102:79], min_clearance_cm[127:103]
    output logic      [127:0] m_axis_tdata
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = $clog2(2 * WINDOW_DEPTH);
    localparam int RW = 56;

    localparam logic [PW-1:0] LAST_IDX = PW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_DEPTH);
    localparam logic [SW-1:0] DEPTH_SW = SW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] TWO_CNT  = CW'(2);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    // Configuration
    logic [19:0] r_warn_cm;
    logic [19:0] r_caution_cm;

    // Ring control
    logic [PW-1:0] r_wp;
    logic [CW-1:0] r_fill;

    // Sequencer
    logic [2:0]    r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_idx;
    logic          r_rv;
    logic          r_rfirst;

    // Working set of one analyze
    logic          r_pos_ok;
    logic          r_terr_ok;
    logic          r_home_ok;
    logic [23:0]   r_terr;
    logic [24:0]   r_agl;
    logic [24:0]   r_homerel;
    logic [24:0]   r_minc;
    logic [23:0]   r_trend;
    logic [23:0]   r_first_alt;
    logic [23:0]   r_last_alt;
    logic [31:0]   r_first_t;
    logic [31:0]   r_last_t;
    logic          r_neg;
    logic [24:0]   r_mag;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_num;

    // Output register
    logic          r_m_valid;
    logic [127:0]  r_m_data;

    // Input fields
    logic [23:0]   in_veh;
    logic [23:0]   in_terr;
    logic [23:0]   in_home;
    logic          in_pos_ok;
    logic          in_terr_ok;
    logic          in_home_ok;

    logic          s_accept;
    logic          do_append;
    logic          cfg_wr;

    logic [SW-1:0] start_raw;
    logic [SW-1:0] start_idx;

    logic          rd_en;
    logic [RW-1:0] rd_data;
    logic [23:0]   rd_alt;
    logic [31:0]   rd_t;
    logic [24:0]   clr;

    logic [24:0]   alt_diff;
    logic          div_done;
    logic [NUM_W-1:0] div_quo;
    logic [23:0]   sat_trend;

    logic          valid_fix;
    logic [2:0]    res_status;
    logic [24:0]   res_agl;
    logic [23:0]   res_trend;
    logic [24:0]   res_minc;
    logic          out_free;

    assign in_veh     = s_axis_tdata[79:56];
    assign in_terr    = s_axis_tdata[103:80];
    assign in_home    = s_axis_tdata[127:104];
    assign in_pos_ok  = s_axis_tdata[128];
    assign in_terr_ok = s_axis_tdata[129];
    assign in_home_ok = s_axis_tdata[130];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign do_append     = s_accept && !s_axis_tuser;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CAUTION) ? {12'd0, r_caution_cm} : {12'd0, r_warn_cm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_cm    <= 20'd2000;
            r_caution_cm <= 20'd5000;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WARNING) begin
                r_warn_cm <= pwdata[19:0];
            end else begin
                r_caution_cm <= pwdata[19:0];
            end
        end
    end

    // ---------------- Sample ring ----------------
    // Oldest stored sample sits n entries behind the write pointer.
    always_comb begin
        start_raw = SW'(r_wp) + DEPTH_SW - SW'(r_fill);
        start_idx = (start_raw >= DEPTH_SW) ? start_raw - DEPTH_SW : start_raw;
    end

    assign rd_en = (r_state == S_SCAN) && (r_cnt != r_n);

    tcm_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata[55:0]),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign rd_alt = rd_data[23:0];
    assign rd_t   = rd_data[55:24];
    assign clr    = {rd_alt[23], rd_alt} - {r_terr[23], r_terr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (do_append) begin
            r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            if (r_fill != FULL_CNT) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // ---------------- Trend divider ----------------
    assign alt_diff = {r_last_alt[23], r_last_alt} - {r_first_alt[23], r_first_alt};

    tcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Magnitude division truncates toward zero; the sign goes back on after.
    always_comb begin
        if (!r_neg) begin
            sat_trend = (div_quo > TREND_POS_LIM) ? TREND_MAX : div_quo[23:0];
        end else begin
            sat_trend = (div_quo > TREND_NEG_LIM) ? TREND_MIN : 24'd0 - div_quo[23:0];
        end
    end

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rv     <= 1'b0;
            r_rfirst <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_accept && s_axis_tuser) begin
                        r_cnt   <= '0;
                        r_state <= (in_pos_ok && in_terr_ok) ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_rv     <= rd_en;
                    r_rfirst <= rd_en && (r_cnt == '0);
                    if (rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_rv) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= ((r_n >= TWO_CNT) && (r_last_t > r_first_t)) ? S_MUL : S_FIN;
                end
                S_MUL: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of one analyze.
    always_ff @(posedge i_clk) begin
        if (s_accept && s_axis_tuser) begin
            r_pos_ok  <= in_pos_ok;
            r_terr_ok <= in_terr_ok;
            r_home_ok <= in_home_ok;
            r_terr    <= in_terr;
            r_agl     <= {in_veh[23], in_veh} - {in_terr[23], in_terr};
            r_minc    <= {in_veh[23], in_veh} - {in_terr[23], in_terr};
            r_homerel <= in_home_ok ? {in_veh[23], in_veh} - {in_home[23], in_home} : 25'd0;
            r_trend   <= '0;
            r_n       <= r_fill;
            r_idx     <= start_idx[PW-1:0];
        end
        if (rd_en) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
        if ((r_state == S_SCAN) && r_rv) begin
            if ($signed(clr) < $signed(r_minc)) begin
                r_minc <= clr;
            end
            if (r_rfirst) begin
                r_first_alt <= rd_alt;
                r_first_t   <= rd_t;
            end
            r_last_alt <= rd_alt;
            r_last_t   <= rd_t;
        end
        if (r_state == S_PREP) begin
            r_neg <= alt_diff[24];
            r_mag <= alt_diff[24] ? 25'd0 - alt_diff : alt_diff;
            r_den <= r_last_t - r_first_t;
        end
        if (r_state == S_MUL) begin
            r_num <= {9'd0, r_mag} * {24'd0, MS_PER_S};
        end
        if ((r_state == S_DWAIT) && div_done) begin
            r_trend <= sat_trend;
        end
    end

    // ---------------- Result ----------------
    assign valid_fix = r_pos_ok && r_terr_ok;
    assign out_free  = !r_m_valid || m_axis_tready;

    always_comb begin
        if (!r_pos_ok) begin
            res_status = ST_NO_POS;
        end else if (!r_terr_ok) begin
            res_status = ST_NO_TERR;
        end else if ($signed(r_minc) < $signed({5'd0, r_warn_cm})) begin
            res_status = ST_WARNING;
        end else if ($signed(r_minc) < $signed({5'd0, r_caution_cm})) begin
            res_status = ST_CAUTION;
        end else begin
            res_status = ST_CLEAR;
        end
        res_agl   = valid_fix ? r_agl : 25'd0;
        res_trend = valid_fix ? r_trend : 24'd0;
        res_minc  = valid_fix ? r_minc : 25'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_m_data <= {res_minc, res_trend, r_terr_ok, r_terr, r_home_ok,
                         r_homerel, res_agl, res_status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ---------------- Checks ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("ring fill count beyond window depth");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST_IDX)
        else $error("ring write pointer out of range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= r_n))
        else $error("scan read past stored samples");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside trend wait");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import tcm_pkg::*;

    localparam int TRAIL_DEPTH = 30;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 600;
    localparam int CHUNKS = 6;
    localparam int CHUNK_BEATS = 175;
    localparam longint TREND_HI = 64'sd8388607;
    localparam longint TREND_LO = -64'sd8388608;

    localparam logic CMD_APPEND  = 1'b0;
    localparam logic CMD_ANALYZE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [23:0] sample_alt;
        logic [31:0] sample_time;
        logic [23:0] veh;
        logic [23:0] terr;
        logic [23:0] home;
        logic        pos_ok;
        logic        terr_ok;
        logic        home_ok;
    } t_nav_beat;

    // Same layout as the output tdata, highest field first.
    typedef struct packed {
        logic [24:0] min_clear;
        logic [23:0] trend;
        logic        terr_valid;
        logic [23:0] terr_echo;
        logic        home_valid;
        logic [24:0] home_rel;
        logic [24:0] agl;
        logic [2:0]  status;
    } t_report;

    typedef struct packed {
        t_nav_beat beat;
        logic      typed;
        t_report   exp;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [127:0]  m_axis_tdata;

    // Predictor state: trail ring and thresholds as the block should hold them.
    logic [23:0]   trail_alt [TRAIL_DEPTH];
    logic [31:0]   trail_time [TRAIL_DEPTH];
    int            trail_wr_ptr = 0;
    int            trail_count = 0;
    logic [19:0]   warn_cm = 20'd2000;
    logic [19:0]   caution_cm = 20'd5000;

    t_report       pending_reports [$];
    t_dir_row      directed [$];
    int            mismatch_count = 0;
    int            reports_seen = 0;
    int unsigned   cycle_count = 0;
    int            tx_idle_pct = 8;
    int            rx_idle_pct = 76;
    logic          rx_hold_go = 1'b0;
    int            rx_hold_left = 0;
    int            scene_base = 0;
    logic [31:0]   trail_clock = '0;

    terrain_clearance_monitor #(
        .WINDOW_DEPTH(TRAIL_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_report report_of(logic [2:0] status, longint agl, longint rel,
                                          logic hv, longint terr, logic tv,
                                          longint trend, longint minc);
        t_report r;
        r.status = status;
        r.agl = 25'(agl);
        r.home_rel = 25'(rel);
        r.home_valid = hv;
        r.terr_echo = 24'(terr);
        r.terr_valid = tv;
        r.trend = 24'(trend);
        r.min_clear = 25'(minc);
        return r;
    endfunction

    function automatic t_dir_row append_row(longint alt, longint unsigned stamp);
        t_dir_row r;
        r = '0;
        r.beat.cmd = CMD_APPEND;
        r.beat.sample_alt = 24'(alt);
        r.beat.sample_time = 32'(stamp);
        return r;
    endfunction

    // ok holds position, terrain and home validity, in that order.
    function automatic t_dir_row analyze_row(longint veh, longint terr, longint home,
                                             logic [2:0] ok, logic typed, t_report exp);
        t_dir_row r;
        r = '0;
        r.beat.cmd = CMD_ANALYZE;
        r.beat.veh = 24'(veh);
        r.beat.terr = 24'(terr);
        r.beat.home = 24'(home);
        {r.beat.pos_ok, r.beat.terr_ok, r.beat.home_ok} = ok;
        r.typed = typed;
        r.exp = exp;
        return r;
    endfunction

    function automatic t_report assess_clearance(t_nav_beat b);
        t_report r;
        longint veh, terr, home, agl, minc, c, first_c, last_c, trend, num, den;
        longint first_t, last_t;
        int start, idx;
        veh = longint'($signed(b.veh));
        terr = longint'($signed(b.terr));
        home = longint'($signed(b.home));
        r = '0;
        r.terr_echo = b.terr;
        r.terr_valid = b.terr_ok;
        r.home_valid = b.home_ok;
        if (b.home_ok)
            r.home_rel = 25'(veh - home);
        if (!b.pos_ok) begin
            r.status = ST_NO_POS;
        end else if (!b.terr_ok) begin
            r.status = ST_NO_TERR;
        end else begin
            agl = veh - terr;
            minc = agl;
            first_c = 0;
            last_c = 0;
            first_t = 0;
            last_t = 0;
            trend = 0;
            start = (trail_wr_ptr + TRAIL_DEPTH - trail_count) % TRAIL_DEPTH;
            for (int k = 0; k < trail_count; k++) begin
                idx = (start + k) % TRAIL_DEPTH;
                c = longint'($signed(trail_alt[idx])) - terr;
                if (c < minc)
                    minc = c;
                if (k == 0) begin
                    first_c = c;
                    first_t = longint'(trail_time[idx]);
                end
                last_c = c;
                last_t = longint'(trail_time[idx]);
            end
            // Trend needs two samples and a strictly later newest timestamp.
            if (trail_count >= 2 && last_t > first_t) begin
                num = (last_c - first_c) * 1000;
                den = last_t - first_t;
                trend = num / den;
                if (trend > TREND_HI)
                    trend = TREND_HI;
                if (trend < TREND_LO)
                    trend = TREND_LO;
            end
            r.agl = 25'(agl);
            r.min_clear = 25'(minc);
            r.trend = 24'(trend);
            if (minc < longint'(warn_cm))
                r.status = ST_WARNING;
            else if (minc < longint'(caution_cm))
                r.status = ST_CAUTION;
            else
                r.status = ST_CLEAR;
        end
        return r;
    endfunction

    function automatic string describe(t_report r);
        return $sformatf("status=%0d agl=%0d rel=%0d hv=%0b terr=%0d tv=%0b trend=%0d min=%0d",
                         r.status, $signed(r.agl), $signed(r.home_rel), r.home_valid,
                         $signed(r.terr_echo), r.terr_valid, $signed(r.trend),
                         $signed(r.min_clear));
    endfunction

    task automatic log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Mostly a plausible flight around a terrain level, with timestamps that
    // never go back; the rest is raw noise over the full field ranges.
    function automatic t_nav_beat random_beat();
        t_nav_beat b;
        b.cmd = ($urandom_range(99) < 45) ? CMD_ANALYZE : CMD_APPEND;
        b.sample_alt = 24'($urandom);
        b.sample_time = $urandom;
        b.veh = 24'($urandom);
        b.terr = 24'($urandom);
        b.home = 24'($urandom);
        b.pos_ok = ($urandom_range(99) < 90);
        b.terr_ok = ($urandom_range(99) < 90);
        b.home_ok = 1'($urandom_range(1));
        if ($urandom_range(99) < 80) begin
            trail_clock = trail_clock + $urandom_range(0, 1500);
            b.sample_time = trail_clock;
            b.sample_alt = 24'(scene_base + int'($urandom_range(0, 40000)) - 4000);
            b.terr = 24'(scene_base + int'($urandom_range(0, 2000)) - 1000);
            b.veh = 24'(scene_base + int'($urandom_range(0, 40000)) - 4000);
            b.home = 24'(scene_base + int'($urandom_range(0, 5000)));
        end
        return b;
    endfunction

    task automatic push_beat(t_nav_beat b, logic typed, t_report exp);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, (tx_idle_pct > 50) ? 90 : 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= b.cmd;
        s_axis_tdata <= {5'b0, b.home_ok, b.terr_ok, b.pos_ok, b.home, b.terr, b.veh,
                         b.sample_time, b.sample_alt};
        do @(posedge i_clk); while (!s_axis_tready);
        if (b.cmd == CMD_APPEND) begin
            trail_alt[trail_wr_ptr] = b.sample_alt;
            trail_time[trail_wr_ptr] = b.sample_time;
            trail_wr_ptr = (trail_wr_ptr + 1) % TRAIL_DEPTH;
            if (trail_count < TRAIL_DEPTH)
                trail_count++;
        end else begin
            pending_reports.push_back(typed ? exp : assess_clearance(b));
        end
    endtask

    // Write one threshold, then read it back in the next transfer.
    task automatic program_threshold(logic reg_sel, logic [19:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {12'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {12'd0, value})
            log_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                                   reg_sel, value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_WARNING)
            warn_cm = value;
        else
            caution_cm = value;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_go) begin
            rx_hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_report got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                log_mismatch({"unexpected result beat: ", describe(got)});
            end else begin
                want = pending_reports.pop_front();
                if (got !== want)
                    log_mismatch($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                           reports_seen, describe(want), describe(got)));
            end
        end
    end

    initial begin
        logic [19:0] warn_next, caution_next;
        t_dir_row row;

        // Reset thresholds: warning below 2000, caution below 5000.
        directed.push_back(analyze_row(100, 7, -50, 3'b011, 1'b1,
                           report_of(ST_NO_POS, 0, 150, 1'b1, 7, 1'b1, 0, 0)));
        directed.push_back(analyze_row(-1, -1, 5, 3'b000, 1'b1,
                           report_of(ST_NO_POS, 0, 0, 1'b0, -1, 1'b0, 0, 0)));
        directed.push_back(analyze_row(8388607, -8388608, 0, 3'b100, 1'b1,
                           report_of(ST_NO_TERR, 0, 0, 1'b0, -8388608, 1'b0, 0, 0)));
        directed.push_back(analyze_row(8388607, -8388608, -8388608, 3'b111, 1'b1,
                           report_of(ST_CLEAR, 16777215, 16777215, 1'b1, -8388608, 1'b1,
                                     0, 16777215)));
        directed.push_back(analyze_row(-8388608, 8388607, 8388607, 3'b111, 1'b1,
                           report_of(ST_WARNING, -16777215, -16777215, 1'b1, 8388607, 1'b1,
                                     0, -16777215)));
        // Thresholds are strict: equal to a threshold is not below it.
        directed.push_back(analyze_row(2000, 0, 0, 3'b110, 1'b1,
                           report_of(ST_CAUTION, 2000, 0, 1'b0, 0, 1'b1, 0, 2000)));
        directed.push_back(analyze_row(1999, 0, 0, 3'b110, 1'b1,
                           report_of(ST_WARNING, 1999, 0, 1'b0, 0, 1'b1, 0, 1999)));
        directed.push_back(analyze_row(5000, 0, 0, 3'b110, 1'b1,
                           report_of(ST_CLEAR, 5000, 0, 1'b0, 0, 1'b1, 0, 5000)));
        directed.push_back(analyze_row(4999, 0, 0, 3'b110, 1'b1,
                           report_of(ST_CAUTION, 4999, 0, 1'b0, 0, 1'b1, 0, 4999)));
        // One stored sample: its clearance counts, but there is no trend yet.
        directed.push_back(append_row(0, 1000));
        directed.push_back(analyze_row(10000, 0, 0, 3'b110, 1'b1,
                           report_of(ST_WARNING, 10000, 0, 1'b0, 0, 1'b1, 0, 0)));
        directed.push_back(append_row(8388607, 1001));
        directed.push_back(analyze_row(-100, 50, 0, 3'b111, 1'b0, '0));
        directed.push_back(append_row(-8388608, 1002));
        directed.push_back(analyze_row(300000, -300000, 12345, 3'b111, 1'b0, '0));
        directed.push_back(append_row(40000, 0));
        directed.push_back(analyze_row(50000, 1000, -8388608, 3'b111, 1'b0, '0));
        directed.push_back(append_row(123, 64'hFFFF_FFFF));
        directed.push_back(analyze_row(-20000, -30000, 8388607, 3'b111, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            row = directed[i];
            push_beat(row.beat, row.typed, row.exp);
        end

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (chunk)
                0: begin warn_next = 20'd0;       caution_next = 20'd1000000; end
                1: begin warn_next = 20'd1000000; caution_next = 20'd0;       end
                2: begin warn_next = 20'd0;       caution_next = 20'd0;       end
                3: begin warn_next = 20'd1000000; caution_next = 20'd1000000; end
                default: begin
                    warn_next = 20'($urandom_range(0, 30000));
                    caution_next = 20'($urandom_range(0, 30000));
                end
            endcase
            program_threshold(REG_WARNING, warn_next);
            program_threshold(REG_CAUTION, caution_next);
            if (chunk == 2) begin
                tx_idle_pct <= 76;
                rx_idle_pct <= 8;
            end else if (chunk == 4) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            scene_base = int'($urandom_range(0, 4000000)) - 2000000;
            // A long receiver stall while beats keep coming fills the block.
            if (chunk == 2) begin
                rx_hold_go <= 1'b1;
                @(posedge i_clk);
                rx_hold_go <= 1'b0;
            end
            for (int n = 0; n < CHUNK_BEATS; n++) begin
                if (chunk == 4 && n == CHUNK_BEATS / 2)
                    drain_results();
                push_beat(random_beat(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tcm_pkg.sv
rtl/tcm_ram.sv
rtl/tcm_div.sv
rtl/terrain_clearance_monitor.sv
bench/testbench.sv
